>>> rtl/unsigned_int_to_ieee_float_unit_macros.svh
// Assertion macros for the unsigned integer to float unit.
// Used by the checker module; the names clk and rst must be in scope.
`ifndef UNSIGNED_INT_TO_IEEE_FLOAT_UNIT_MACROS_SVH
`define UNSIGNED_INT_TO_IEEE_FLOAT_UNIT_MACROS_SVH

// Antecedent implies consequent, checked outside reset
`define UITF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Expression never true outside reset
`define UITF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

>>> rtl/uitf_pkg.sv
// Package for the unsigned integer to float unit: word types, codes, stage structs.
// No dependencies.
`timescale 1ns / 1ps

package uitf_pkg;

  localparam int unsigned SRC_W   = 64;
  localparam int unsigned RES_W   = 64;
  localparam int unsigned MSB_W   = 6;
  localparam int unsigned GROUPS  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [7:0]  SP_EXP_OFFSET = 8'd127;
  localparam logic [10:0] DP_EXP_OFFSET = 11'd1023;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_UP      = 2'd2,
    RM_DOWN    = 2'd3
  } rmode_t;

  typedef enum logic [1:0] {
    OP_U32_SGL = 2'd0,
    OP_U32_DBL = 2'd1,
    OP_U64_SGL = 2'd2,
    OP_U64_DBL = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_RND_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAP_ENABLE = 2'd1;

  typedef struct packed {
    opcode_t           opcode;
    logic [SRC_W-1:0]  source_value;
  } uitf_in_t;

  typedef struct packed {
    logic [RES_W-1:0]  result_bits;
    logic              trap_taken;
    logic              inexact_sticky;
  } uitf_out_t;

  typedef struct packed {
    rmode_t rnd_mode;
    logic   trap_enable;
  } uitf_cfg_t;

  // after the byte scan
  typedef struct packed {
    logic                    valid;
    logic                    dbl;
    logic [SRC_W-1:0]        value;
    logic [GROUPS-1:0]       nz;
    logic [GROUPS-1:0][2:0]  pos;
  } uitf_scan_t;

  // leading-one position known, value possibly normalized
  typedef struct packed {
    logic              valid;
    logic              dbl;
    logic              zero;
    logic [MSB_W-1:0]  msb;
    logic [SRC_W-1:0]  value;
  } uitf_norm_t;

endpackage

>>> rtl/uitf_lzd.sv
// Leading-one detector: byte scan stage, then group pick stage.
// Depends on uitf_pkg.
`timescale 1ns / 1ps

module uitf_lzd (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  uitf_pkg::uitf_in_t operand,
  output uitf_pkg::uitf_norm_t lzd_out
);

  uitf_pkg::uitf_scan_t scan;
  uitf_pkg::uitf_scan_t scan_next;
  uitf_pkg::uitf_norm_t pick_next;

  // leading one inside one byte
  function automatic logic [2:0] lead8(input logic [7:0] b);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

  // mask the source and scan each byte
  always_comb begin
    scan_next       = '0;
    scan_next.valid = accept;
    scan_next.dbl   = operand.opcode[0];
    scan_next.value = operand.opcode[1] ? operand.source_value
                                        : {32'd0, operand.source_value[31:0]};
    for (int g = 0; g < uitf_pkg::GROUPS; g++) begin
      scan_next.nz[g]  = |scan_next.value[8*g +: 8];
      scan_next.pos[g] = lead8(scan_next.value[8*g +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan.valid <= 1'b0;
    end else begin
      scan.valid <= scan_next.valid;
    end
    scan.dbl   <= scan_next.dbl;
    scan.value <= scan_next.value;
    scan.nz    <= scan_next.nz;
    scan.pos   <= scan_next.pos;
  end

  // pick the highest nonzero byte
  always_comb begin
    pick_next       = '0;
    pick_next.valid = scan.valid;
    pick_next.dbl   = scan.dbl;
    pick_next.value = scan.value;
    pick_next.zero  = ~|scan.nz;
    for (int g = 0; g < uitf_pkg::GROUPS; g++) begin
      if (scan.nz[g]) pick_next.msb = {3'(g), scan.pos[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lzd_out.valid <= 1'b0;
    end else begin
      lzd_out.valid <= pick_next.valid;
    end
    lzd_out.dbl   <= pick_next.dbl;
    lzd_out.zero  <= pick_next.zero;
    lzd_out.msb   <= pick_next.msb;
    lzd_out.value <= pick_next.value;
  end

endmodule

>>> rtl/uitf_norm.sv
// Normalizing shifter: byte-step shift stage, then bit-step shift stage.
// Depends on uitf_pkg.
`timescale 1ns / 1ps

module uitf_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  uitf_pkg::uitf_norm_t norm_in,
  output uitf_pkg::uitf_norm_t norm_out
);

  uitf_pkg::uitf_norm_t coarse;
  logic [uitf_pkg::MSB_W-1:0] shamt_in;
  logic [2:0]                 shamt_fine;

  // shift amount is 63 - msb
  assign shamt_in   = ~norm_in.msb;
  assign shamt_fine = ~coarse.msb[2:0];

  // shift by whole bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      coarse.valid <= 1'b0;
    end else begin
      coarse.valid <= norm_in.valid;
    end
    coarse.dbl   <= norm_in.dbl;
    coarse.zero  <= norm_in.zero;
    coarse.msb   <= norm_in.msb;
    coarse.value <= norm_in.value << {shamt_in[5:3], 3'b000};
  end

  // finish with the bit shift; leading one lands on bit 63
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_out.valid <= 1'b0;
    end else begin
      norm_out.valid <= coarse.valid;
    end
    norm_out.dbl   <= coarse.dbl;
    norm_out.zero  <= coarse.zero;
    norm_out.msb   <= coarse.msb;
    norm_out.value <= coarse.value << shamt_fine;
  end

endmodule

>>> rtl/uitf_round.sv
// Rounding stage: builds exponent and fraction, rounds, tracks the sticky flag.
// Depends on uitf_pkg.
`timescale 1ns / 1ps

module uitf_round (
  input  logic                 clk,
  input  logic                 rst,
  input  uitf_pkg::uitf_cfg_t  cfg,
  input  uitf_pkg::uitf_norm_t norm_in,
  output logic                 done,
  output uitf_pkg::uitf_out_t  result
);

  logic        flag;
  logic        flag_next;
  logic        lsb, guard, stick, inexact, inc;
  logic [7:0]  exp_s;
  logic [10:0] exp_d;
  logic [30:0] sum_s;
  logic [62:0] sum_d;
  uitf_pkg::uitf_out_t result_next;

  always_comb begin
    // select rounding bits by format
    if (norm_in.dbl) begin
      lsb   = norm_in.value[11];
      guard = norm_in.value[10];
      stick = |norm_in.value[9:0];
    end else begin
      lsb   = norm_in.value[40];
      guard = norm_in.value[39];
      stick = |norm_in.value[38:0];
    end
    inexact = ~norm_in.zero & (guard | stick);

    // round increment by mode; down acts as truncate for positive values
    case (cfg.rnd_mode)
      uitf_pkg::RM_NEAREST: inc = guard & (stick | lsb);
      uitf_pkg::RM_UP:      inc = guard | stick;
      default:              inc = 1'b0;
    endcase

    // exponent plus fraction, carry of the increment runs into exponent
    exp_s = {2'b00, norm_in.msb} + uitf_pkg::SP_EXP_OFFSET;
    exp_d = {5'b00000, norm_in.msb} + uitf_pkg::DP_EXP_OFFSET;
    sum_s = {exp_s, norm_in.value[62:40]} + {30'd0, inc};
    sum_d = {exp_d, norm_in.value[62:11]} + {62'd0, inc};

    result_next = '0;
    if (!norm_in.zero) begin
      result_next.result_bits = norm_in.dbl ? {1'b0, sum_d} : {33'd0, sum_s};
    end
    result_next.trap_taken = inexact & cfg.trap_enable;
    flag_next = flag | (inexact & ~cfg.trap_enable);
    result_next.inexact_sticky = flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      flag <= 1'b0;
    end else begin
      done <= norm_in.valid;
      if (norm_in.valid) flag <= flag_next;
    end
    result <= result_next;
  end

endmodule

>>> rtl/unsigned_int_to_ieee_float_unit.sv
// Top level of the unsigned integer to IEEE float converter.
// Depends on uitf_pkg, uitf_lzd, uitf_norm, uitf_round.
//
//   channel   ports                            dir   handshake
//   --------  -------------------------------  ----  -------------------------
//   command   start, busy, operand             in    start && !busy
//   result    done, result                     out   done strobe, one cycle
//   config    cfg_valid, cfg_ready, cfg_index,  in    cfg_valid && cfg_ready
//             cfg_data
//
// One word enters per cycle; each result passes through one register stage
// each for byte scan, group pick, byte shift, bit shift and rounding.
// busy stays low and cfg_ready stays high.
// Synchronous reset clears the stage valid bits, the sticky inexact flag and
// the configuration registers. The result side has no stall.
`timescale 1ns / 1ps

module unsigned_int_to_ieee_float_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  uitf_pkg::uitf_in_t                  operand,
  output logic                                done,
  output uitf_pkg::uitf_out_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uitf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uitf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  uitf_pkg::uitf_cfg_t  cfg;
  uitf_pkg::uitf_norm_t lzd_q;
  uitf_pkg::uitf_norm_t norm_q;
  logic                 accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rnd_mode    <= uitf_pkg::RM_NEAREST;
      cfg.trap_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uitf_pkg::CFG_RND_MODE:    cfg.rnd_mode    <= uitf_pkg::rmode_t'(cfg_data);
        uitf_pkg::CFG_TRAP_ENABLE: cfg.trap_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  uitf_lzd u_lzd (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .operand (operand),
    .lzd_out (lzd_q)
  );

  uitf_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .norm_in  (lzd_q),
    .norm_out (norm_q)
  );

  uitf_round u_round (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .norm_in (norm_q),
    .done    (done),
    .result  (result)
  );

endmodule

>>> rtl/uitf_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on uitf_pkg and unsigned_int_to_ieee_float_unit_macros.svh.
`timescale 1ns / 1ps
`include "unsigned_int_to_ieee_float_unit_macros.svh"

module uitf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input uitf_pkg::uitf_out_t             result
);

  // every accepted word gives a result
  `UITF_ASSERT_IMP(a_start_done, start && !busy, ##5 done, "accepted word gave no result")
  // no result without an earlier accepted word
  `UITF_ASSERT_IMP(a_done_start, done, $past(start && !busy, 5), "result without a word")
  // a trap comes only with a nonzero result
  `UITF_ASSERT_NEVER(a_trap_zero, done && result.trap_taken && result.result_bits == '0,
    "trap on a zero result")
  // once the sticky flag shows on a result, a result in the next cycle keeps it set
  `UITF_ASSERT_IMP(a_sticky_hold, done && result.inexact_sticky, ##1 !done ||
    result.inexact_sticky, "sticky flag cleared")

endmodule

bind unsigned_int_to_ieee_float_unit uitf_checker u_uitf_checker (.*);
